// ===== design/bicubic_pixel_interpolator_defines.svh =====
// ---------------------------------------------------------------------------
// Bicubic pixel interpolator assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BICUBIC_PIXEL_INTERPOLATOR_DEFINES_SVH
`define BICUBIC_PIXEL_INTERPOLATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bpi_pkg.sv =====
// ---------------------------------------------------------------------------
// Bicubic pixel interpolator package
// Widths, register indexes, reset values and weight types of the block.
// ---------------------------------------------------------------------------
package bpi_pkg;

  // Fraction precision of the kernel weights (4 to 16).
  localparam int FRAC_BITS = 16;

  localparam int IN_FRAC_W = 16;
  localparam int PIX_W     = 16;
  localparam int TAPS      = 4;
  localparam int ROW_W     = TAPS * PIX_W;

  localparam int SHARP_W   = 16;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SHARPNESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'd1;

  localparam logic [SHARP_W-1:0] SHARP_RST = 16'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd65536;

  // Weight generator widths.
  localparam int D_W  = FRAC_BITS;
  localparam int E_W  = FRAC_BITS + 1;
  localparam int DE_W = 2 * FRAC_BITS - 1;   // d*e never exceeds 2^(2F-2)
  localparam int DD_W = 2 * FRAC_BITS;
  localparam int K_W  = FRAC_BITS + 2;
  localparam int P_W  = 3 * FRAC_BITS - 2;   // d*e*e and d*d*e stay below 2^(3F-2)
  localparam int N_W  = P_W + SHARP_W;
  localparam int N2_W = 3 * FRAC_BITS;
  localparam int WS   = SHARP_W + 2 * FRAC_BITS;
  localparam int TS   = 2 * FRAC_BITS;
  localparam int Q_W  = FRAC_BITS + 1;
  localparam int W_W  = FRAC_BITS + 3;

  localparam logic [FRAC_BITS:0]   FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [K_W-1:0]       THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic [N_W:0]         N_HALF    = (N_W + 1)'(1) << (WS - 1);
  localparam logic [N2_W:0]        T_HALF    = (N2_W + 1)'(1) << (TS - 1);
  localparam logic [W_W+1:0]       WSUM_ONE  = {4'b0000, FRAC_ONE};

  // Filter datapath widths.
  localparam int HP_W      = PIX_W + 1 + W_W;
  localparam int HS_W      = HP_W + 2;
  localparam int VP_W      = HS_W + W_W;
  localparam int V_W       = VP_W + 2;
  localparam int HI_W      = V_W - 1 - GAIN_W;
  localparam int HG_W      = HI_W + GAIN_W;
  localparam int LG_W      = 2 * GAIN_W;
  localparam int ACC_W     = HG_W + 1;
  localparam int OUT_SHIFT = 2 * FRAC_BITS + GAIN_FRAC - GAIN_W;

  // Pipeline depth: weight generator, then three horizontal, three vertical
  // and three gain stages.
  localparam int WGT_LAT  = 5;
  localparam int PIPE_LAT = WGT_LAT + 9;

  typedef logic signed [W_W-1:0] weight_t;
  typedef weight_t wvec_t [TAPS];

endpackage

// ===== design/bpi_weights.sv =====
// ---------------------------------------------------------------------------
// Cubic convolution weight generator
// Five-stage pipeline that turns one fraction into four signed kernel taps.
// ---------------------------------------------------------------------------
module bpi_weights (
  input  logic                          clk,
  input  logic [bpi_pkg::IN_FRAC_W-1:0] frac,
  input  logic [bpi_pkg::SHARP_W-1:0]   sharpness,
  output bpi_pkg::wvec_t                weights
);
  import bpi_pkg::*;

  logic [D_W-1:0]        d_nxt, d_r;
  logic [E_W-1:0]        e_nxt, e_r;
  logic [D_W+E_W-1:0]    de_full;
  logic [DE_W-1:0]       de_r;
  logic [DD_W-1:0]       dd_nxt, dd_r;
  logic [K_W-1:0]        k_nxt, k_r;

  logic [DE_W+E_W-1:0]   p0_full;
  logic [DE_W+D_W-1:0]   p3_full;
  logic [DD_W+K_W-1:0]   n2_full;
  logic [P_W-1:0]        p0_r, p3_r;
  logic [N2_W-1:0]       n2_r;

  logic [N_W-1:0]        n0_nxt, n3_nxt, n0_r, n3_r;
  logic [N2_W:0]         t2_sum;
  logic [Q_W-1:0]        t2_r;

  logic [N_W:0]          q0_sum, q3_sum;
  logic [Q_W-1:0]        q0_r, q3_r, t2d_r;

  wvec_t                 w_nxt, w_r;

  // Stage 1: d, e = 1 - d, d*e, d*d and 3 - 2d.
  always_comb begin
    d_nxt   = frac[IN_FRAC_W-1 -: FRAC_BITS];
    e_nxt   = FRAC_ONE - {1'b0, d_nxt};
    de_full = d_nxt * e_nxt;
    dd_nxt  = d_nxt * d_nxt;
    k_nxt   = THREE_ONE - {1'b0, d_nxt, 1'b0};
  end

  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    e_r  <= e_nxt;
    de_r <= de_full[DE_W-1:0];
    dd_r <= dd_nxt;
    k_r  <= k_nxt;
  end

  // Stage 2: the cubic terms without the sharpness factor.
  always_comb begin
    p0_full = de_r * e_r;
    p3_full = de_r * d_r;
    n2_full = dd_r * k_r;
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_full[P_W-1:0];
    p3_r <= p3_full[P_W-1:0];
    n2_r <= n2_full[N2_W-1:0];
  end

  // Stage 3: scale by sharpness; round the smooth-step term.
  always_comb begin
    n0_nxt = sharpness * p0_r;
    n3_nxt = sharpness * p3_r;
    t2_sum = {1'b0, n2_r} + T_HALF;
  end

  always_ff @(posedge clk) begin
    n0_r <= n0_nxt;
    n3_r <= n3_nxt;
    t2_r <= t2_sum[N2_W -: Q_W];
  end

  // Stage 4: round the two sharpness terms, half rounded up.
  always_comb begin
    q0_sum = {1'b0, n0_r} + N_HALF;
    q3_sum = {1'b0, n3_r} + N_HALF;
  end

  always_ff @(posedge clk) begin
    q0_r  <= Q_W'(q0_sum[N_W:WS]);
    q3_r  <= Q_W'(q3_sum[N_W:WS]);
    t2d_r <= t2_r;
  end

  // Stage 5: the four taps, which always sum to exactly one.
  always_comb begin
    w_nxt[0] = $signed({2'b00, q0_r});
    w_nxt[1] = $signed({2'b00, FRAC_ONE}) - $signed({2'b00, t2d_r})
               - $signed({2'b00, q3_r});
    w_nxt[2] = $signed({2'b00, t2d_r}) - $signed({2'b00, q0_r});
    w_nxt[3] = $signed({2'b00, q3_r});
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  always_comb begin
    weights = w_r;
  end

endmodule

// ===== design/bicubic_pixel_interpolator.sv =====
// ---------------------------------------------------------------------------
// Bicubic pixel interpolator
// Cubic convolution of a 4x4 window with programmable sharpness and gain.
// ---------------------------------------------------------------------------
// Usage:
//   Input words are taken at a rising edge where start is high and busy is
//   low. A word is four packed window rows plus the x and y fractions.
//   busy is high only while reset is applied and until the first clock
//   edge after its release; then the block takes one word in every cycle.
//   Each result appears on out_pixel for one cycle with out_valid high,
//   in input order. Throughput is one pixel per clock. The pipeline depth
//   comes from the weight generator (five stages of multiply and round)
//   followed by three horizontal filter stages, three vertical filter
//   stages and three gain and clamp stages.
//   The receiver cannot stall the output, so the pipeline never holds.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 is
//   sharpness, 1 is gain) at the clock edge; write only while no words are
//   in flight. Reset loads sharpness 0.5 and gain 1.0 and empties the
//   pipeline.
// ---------------------------------------------------------------------------
`include "bicubic_pixel_interpolator_defines.svh"

module bicubic_pixel_interpolator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpi_pkg::ROW_W-1:0]     in_row_0,
  input  logic [bpi_pkg::ROW_W-1:0]     in_row_1,
  input  logic [bpi_pkg::ROW_W-1:0]     in_row_2,
  input  logic [bpi_pkg::ROW_W-1:0]     in_row_3,
  input  logic [bpi_pkg::IN_FRAC_W-1:0] in_frac_x,
  input  logic [bpi_pkg::IN_FRAC_W-1:0] in_frac_y,
  output logic                          out_valid,
  output logic [bpi_pkg::PIX_W-1:0]     out_pixel,
  input  logic                          cfg_we,
  input  logic [bpi_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bpi_pkg::CFG_W-1:0]     cfg_wdata
);
  import bpi_pkg::*;

  localparam int V_WGT = WGT_LAT - 1;

  logic                     busy_r;
  logic                     accept;
  logic [SHARP_W-1:0]       sharp_nxt, sharp_r;
  logic [GAIN_W-1:0]        gain_nxt, gain_r;
  logic [PIPE_LAT-1:0]      vld_nxt, vld_r;

  logic [ROW_W-1:0]         row_in [TAPS];
  logic [ROW_W-1:0]         row_dly_r [WGT_LAT][TAPS];
  wvec_t                    wx, wy;
  wvec_t                    wy_dly_r [3];

  logic signed [HP_W-1:0]   hp_r [TAPS][TAPS];
  logic signed [HP_W:0]     hs_r [TAPS][2];
  logic signed [HS_W-1:0]   row_r [TAPS];
  logic signed [VP_W-1:0]   vp_r [TAPS];
  logic signed [VP_W:0]     vs_r [2];
  logic signed [V_W-1:0]    v_r;

  logic                     pos_r, pos2_r;
  logic [HG_W-1:0]          hg_r;
  logic [LG_W-1:0]          lg_r;
  logic [ACC_W-1:0]         acc_r;
  logic [PIX_W-1:0]         pixel_nxt, pixel_r;

  logic [W_W+1:0]           wx_sum, wy_sum;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration registers.
  always_comb begin
    sharp_nxt = sharp_r;
    gain_nxt  = gain_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SHARPNESS: sharp_nxt = cfg_wdata[SHARP_W-1:0];
        REG_GAIN:      gain_nxt  = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sharp_r <= SHARP_RST;
      gain_r  <= GAIN_RST;
    end else begin
      sharp_r <= sharp_nxt;
      gain_r  <= gain_nxt;
    end
  end

  // Valid bits travel alongside the data; the pipeline never stalls.
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Weight generators for both axes.
  bpi_weights u_wgt_x (
    .clk       (clk),
    .frac      (in_frac_x),
    .sharpness (sharp_r),
    .weights   (wx)
  );

  bpi_weights u_wgt_y (
    .clk       (clk),
    .frac      (in_frac_y),
    .sharpness (sharp_r),
    .weights   (wy)
  );

  // The window waits for its weights.
  always_comb begin
    row_in[0] = in_row_0;
    row_in[1] = in_row_1;
    row_in[2] = in_row_2;
    row_in[3] = in_row_3;
  end

  always_ff @(posedge clk) begin
    row_dly_r[0] <= row_in;
    for (int k = 1; k < WGT_LAT; k++) begin
      row_dly_r[k] <= row_dly_r[k-1];
    end
  end

  // Horizontal filter: products, pair sums, row sums.
  always_ff @(posedge clk) begin
    for (int r = 0; r < TAPS; r++) begin
      for (int i = 0; i < TAPS; i++) begin
        hp_r[r][i] <= $signed({1'b0, row_dly_r[WGT_LAT-1][r][i*PIX_W +: PIX_W]}) * wx[i];
      end
      for (int j = 0; j < 2; j++) begin
        hs_r[r][j] <= hp_r[r][2*j] + hp_r[r][2*j+1];
      end
      row_r[r] <= hs_r[r][0] + hs_r[r][1];
    end
  end

  // The y taps follow the horizontal stages.
  always_ff @(posedge clk) begin
    wy_dly_r[0] <= wy;
    wy_dly_r[1] <= wy_dly_r[0];
    wy_dly_r[2] <= wy_dly_r[1];
  end

  // Vertical filter.
  always_ff @(posedge clk) begin
    for (int r = 0; r < TAPS; r++) begin
      vp_r[r] <= row_r[r] * wy_dly_r[2][r];
    end
    vs_r[0] <= vp_r[0] + vp_r[1];
    vs_r[1] <= vp_r[2] + vp_r[3];
    v_r     <= vs_r[0] + vs_r[1];
  end

  // Gain: the positive sum is split at the gain width so that each
  // multiplier stays narrow; the recombined product is a plain floor.
  always_ff @(posedge clk) begin
    pos_r  <= !v_r[V_W-1] && (v_r != '0);
    hg_r   <= v_r[V_W-2:GAIN_W] * gain_r;
    lg_r   <= v_r[GAIN_W-1:0] * gain_r;
    pos2_r <= pos_r;
    acc_r  <= {1'b0, hg_r} + ACC_W'(lg_r[LG_W-1:GAIN_W]);
  end

  always_comb begin
    if (!pos2_r) begin
      pixel_nxt = '0;
    end else if (acc_r[ACC_W-1:OUT_SHIFT+PIX_W] != '0) begin
      pixel_nxt = '1;
    end else begin
      pixel_nxt = acc_r[OUT_SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_pixel = pixel_r;

  // Tap sums for the checks below.
  always_comb begin
    wx_sum = '0;
    wy_sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      wx_sum = wx_sum + (W_W+2)'(wx[i]);
      wy_sum = wy_sum + (W_W+2)'(wy[i]);
    end
  end

  `BPI_ASSERT_IMP(wx_unity_chk, vld_r[V_WGT], wx_sum == WSUM_ONE, "x taps do not sum to one")
  `BPI_ASSERT_IMP(wy_unity_chk, vld_r[V_WGT], wy_sum == WSUM_ONE, "y taps do not sum to one")
  `BPI_ASSERT_NXT(nonpos_zero_chk, vld_r[PIPE_LAT-2] && !pos2_r, out_valid && (out_pixel == '0), "non-positive sum gave a nonzero pixel")

endmodule
